@@ rtl/differential_drive_odometry_unit_macros.svh @@
// assertion shorthands for the odometry checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// condition implies consequence in the next cycle
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry check failed");

// condition implies consequence in the same cycle
`define DDO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry check failed");

`endif

@@ rtl/ddo_pkg.sv @@
package ddo_pkg;

  // angle units of 2^-28 rad
  localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
  localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [32:0] Q28_ONE     = 33'sd268435456;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;
  localparam logic [63:0]        SINC_SMALL  = 64'd33554432;

  // series divisors and velocity scales
  localparam logic [63:0] SINC_DIV3 = 64'd6;
  localparam logic [63:0] SINC_DIV5 = 64'd120;
  localparam logic [31:0] LIN_SCALE = 32'd500000;
  localparam logic [31:0] ANG_SCALE = 32'd1000000;

  // shared serial units
  localparam int DIV_NW = 96;
  localparam int DIV_DW = 64;
  localparam int MUL_AW = 96;
  localparam int MUL_BW = 32;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DIV_TURN, ST_SINC_SEL, ST_MUL_H2, ST_H2, ST_DIV_H2, ST_H4MUL,
    ST_MUL_H4, ST_H4, ST_DIV_H4, ST_SINC_SMALL, ST_DIV_WRAPH, ST_WRAPH,
    ST_CORDIC_H, ST_SINC_DIV, ST_DIV_SINC, ST_SINC_BIG, ST_CHORD, ST_MUL_CHORD,
    ST_HDW, ST_DIV_WRAPM, ST_WRAPM, ST_CORDIC_M, ST_DX, ST_MUL_DX, ST_DY,
    ST_MUL_DY, ST_HD, ST_DIV_WRAPT, ST_LIN, ST_MUL_LIN, ST_LIN_DIV, ST_DIV_LIN,
    ST_ANG, ST_MUL_ANG, ST_ANG_DIV, ST_DIV_ANG, ST_DONE, ST_OUT
  } state_e;

  // arctangent of 2^-k in angle units
  function automatic logic [31:0] atan_unit(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      5'd24: v = 32'd16;
      5'd25: v = 32'd8;
      5'd26: v = 32'd4;
      5'd27: v = 32'd2;
      5'd28: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // signed remainder modulo two pi folded into [-pi, pi]
  function automatic logic signed [30:0] wrap_fix(input logic neg, input logic [63:0] rem);
    logic signed [32:0] r;
    r = $signed({1'b0, rem[31:0]});
    if (neg) r = -r;
    if (r > ANG_PI) r = r - ANG_TWO_PI;
    else if (r < -ANG_PI) r = r + ANG_TWO_PI;
    return r[30:0];
  endfunction

  // sign and magnitude to saturated 32-bit signed
  function automatic logic signed [31:0] sat32(input logic neg, input logic [95:0] q);
    logic signed [31:0] v;
    if (neg) begin
      if (q > 96'h80000000) v = 32'sh80000000;
      else v = -$signed(q[31:0]);
    end else begin
      if (q > 96'h7FFFFFFF) v = 32'sh7FFFFFFF;
      else v = $signed(q[31:0]);
    end
    return v;
  endfunction

endpackage

@@ rtl/differential_drive_odometry_unit.sv @@
// Differential-drive odometry: each input request carries right and left wheel travel
// (Q16.16 m) and elapsed time (us); the block updates the pose (x, y in Q32.16 m,
// heading in 2^-28 rad wrapped to plus/minus pi) and returns one result with pose and
// linear and angular velocity. One item at a time: an item takes seven passes through
// the shared 96-step restoring divider, seven 32-step shift-add multiplies when the
// half turn is small (series sinc) or five when it is large, and one CORDIC run of
// CORDIC_STEPS steps when small or two when large; zero elapsed time skips the velocity
// stage (two divides, two multiplies). The input reopens the cycle after the result is
// loaded. The result sits in an output register, so a waiting result does not hold off
// the next input. wheel_separation is to be written by the user on its own port only
// while idle; the block itself does not enforce this.
module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS  = 24,
  parameter int POSITION_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // right_distance [31:0], left_distance [63:32], elapsed_time [95:64]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pose_x [47:0], pose_y [95:48], heading [126:96], linear_velocity [158:127],
  // angular_velocity [190:159], zero [191]
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);
  import ddo_pkg::*;

  localparam int SumW = ((POSITION_BITS > 48) ? POSITION_BITS : 48) + 2;
  localparam logic signed [SumW-1:0] PosMax = (SumW'(1) <<< (POSITION_BITS - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] PosMin = -PosMax - SumW'(1);
  localparam logic signed [SumW-1:0] OutMax = (SumW'(1) <<< 47) - SumW'(1);
  localparam logic signed [SumW-1:0] OutMin = -OutMax - SumW'(1);

  function automatic logic signed [POSITION_BITS-1:0] sat_pos(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = (v > PosMax) ? PosMax : ((v < PosMin) ? PosMin : v);
    return r[POSITION_BITS-1:0];
  endfunction

  function automatic logic [47:0] sat_out(input logic signed [POSITION_BITS-1:0] p);
    logic signed [SumW-1:0] e;
    logic signed [SumW-1:0] r;
    e = {{(SumW - POSITION_BITS){p[POSITION_BITS-1]}}, p};
    r = (e > OutMax) ? OutMax : ((e < OutMin) ? OutMin : e);
    return r[47:0];
  endfunction

  state_e state_q, state_d;

  // pose and configuration
  logic [30:0]                     w_q;
  logic signed [POSITION_BITS-1:0] px_q, py_q;
  logic signed [30:0]              hd_q;

  // per-item working registers
  logic signed [32:0] sum_q;
  logic [31:0]        dt_q;
  logic               sgn_q;
  logic signed [63:0] turn_q, half_q, chord_q;
  logic signed [32:0] sinc_q;
  logic [31:0]        h2_q, t1_q;
  logic signed [31:0] sin_q, lin_q, ang_q;

  logic         m_valid_q;
  logic [191:0] m_data_q;

  // divider
  logic [DIV_NW-1:0] dq_q;
  logic [DIV_DW-1:0] dr_q, dd_q;
  logic [6:0]        dcnt_q;
  logic              dbusy_q, div_done, div_start;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_DW:0]   div_t, div_s;

  // multiplier
  logic [MUL_AW-1:0] ma_q, mp_q;
  logic [MUL_BW-1:0] mb_q;
  logic [4:0]        mcnt_q;
  logic              mbusy_q, mul_done, mul_start;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;

  // cordic
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [4:0]         ccnt_q;
  logic               cneg_q, cbusy_q, cor_done, cor_start;
  logic signed [30:0] cor_ang;
  logic signed [32:0] cang_e;
  logic signed [31:0] cor_c, cor_s;

  logic out_load;

  // helpers
  logic signed [32:0] in_sum, in_diff;
  logic [32:0]        diff_mag, sum_abs, sinc_abs;
  logic [63:0]        qmag, hmag, half_abs, chord_abs, turn_abs, hdh_abs, hdt_abs;
  logic signed [63:0] turn_v, half_v, hdh, hdt;
  logic [31:0]        cor_c_abs, cor_s_abs, sin_abs;
  logic signed [96:0] sp, sp_r28, sp_r29;
  logic signed [SumW-1:0] d_ext, px_ext, py_ext;

  assign in_sum   = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                  + $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
  assign in_diff  = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                  - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
  assign diff_mag = in_diff[32] ? 33'(-in_diff) : 33'(in_diff);
  assign sum_abs  = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
  assign sinc_abs = sinc_q[32] ? 33'(-sinc_q) : 33'(sinc_q);

  assign qmag   = dq_q[63:0];
  assign hmag   = qmag >> 1;
  assign turn_v = sgn_q ? -$signed(qmag) : $signed(qmag);
  assign half_v = sgn_q ? -$signed(hmag) : $signed(hmag);

  assign half_abs  = half_q[63] ? 64'(-half_q) : 64'(half_q);
  assign chord_abs = chord_q[63] ? 64'(-chord_q) : 64'(chord_q);
  assign turn_abs  = turn_q[63] ? 64'(-turn_q) : 64'(turn_q);
  assign hdh       = {{33{hd_q[30]}}, hd_q} + half_q;
  assign hdt       = {{33{hd_q[30]}}, hd_q} + turn_q;
  assign hdh_abs   = hdh[63] ? 64'(-hdh) : 64'(hdh);
  assign hdt_abs   = hdt[63] ? 64'(-hdt) : 64'(hdt);

  assign cor_c     = cneg_q ? -cx_q : cx_q;
  assign cor_s     = cneg_q ? -cy_q : cy_q;
  assign cor_c_abs = cor_c[31] ? 32'(-cor_c) : 32'(cor_c);
  assign cor_s_abs = cor_s[31] ? 32'(-cor_s) : 32'(cor_s);
  assign sin_abs   = sin_q[31] ? 32'(-sin_q) : 32'(sin_q);

  // signed product with floor shifts
  assign sp     = sgn_q ? -$signed({1'b0, mp_q}) : $signed({1'b0, mp_q});
  assign sp_r28 = sp >>> 28;
  assign sp_r29 = sp >>> 29;
  assign d_ext  = sp_r28[SumW-1:0];
  assign px_ext = {{(SumW - POSITION_BITS){px_q[POSITION_BITS-1]}}, px_q};
  assign py_ext = {{(SumW - POSITION_BITS){py_q[POSITION_BITS-1]}}, py_q};

  // divider step
  assign div_t    = {dr_q, dq_q[DIV_NW-1]};
  assign div_s    = div_t - {1'b0, dd_q};
  assign div_done = dbusy_q && (dcnt_q == 7'(DIV_NW - 1));
  assign mul_done = mbusy_q && (mcnt_q == 5'(MUL_BW - 1));
  assign cor_done = cbusy_q && (ccnt_q == 5'(CORDIC_STEPS - 1));
  assign cang_e   = {cor_ang[30], cor_ang[30], cor_ang};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_ang   = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) begin
        div_start = 1'b1;
        div_n     = 96'(diff_mag) << 28;
        div_d     = 64'(w_q);
        state_d   = ST_DIV_TURN;
      end
      ST_DIV_TURN: if (div_done) state_d = ST_SINC_SEL;
      ST_SINC_SEL: begin
        if (hmag < SINC_SMALL) begin
          mul_start = 1'b1;
          mul_a     = 96'(hmag);
          mul_b     = hmag[31:0];
          state_d   = ST_MUL_H2;
        end else begin
          div_start = 1'b1;
          div_n     = 96'(hmag);
          div_d     = 64'(ANG_TWO_PI);
          state_d   = ST_DIV_WRAPH;
        end
      end
      ST_MUL_H2: if (mul_done) state_d = ST_H2;
      ST_H2: begin
        div_start = 1'b1;
        div_n     = 96'(mp_q[59:28]);
        div_d     = SINC_DIV3;
        state_d   = ST_DIV_H2;
      end
      ST_DIV_H2: if (div_done) state_d = ST_H4MUL;
      ST_H4MUL: begin
        mul_start = 1'b1;
        mul_a     = 96'(h2_q);
        mul_b     = h2_q;
        state_d   = ST_MUL_H4;
      end
      ST_MUL_H4: if (mul_done) state_d = ST_H4;
      ST_H4: begin
        div_start = 1'b1;
        div_n     = 96'(mp_q[59:28]);
        div_d     = SINC_DIV5;
        state_d   = ST_DIV_H4;
      end
      ST_DIV_H4: if (div_done) state_d = ST_SINC_SMALL;
      ST_SINC_SMALL: state_d = ST_CHORD;
      ST_DIV_WRAPH: if (div_done) state_d = ST_WRAPH;
      ST_WRAPH: begin
        cor_start = 1'b1;
        cor_ang   = wrap_fix(sgn_q, dr_q);
        state_d   = ST_CORDIC_H;
      end
      ST_CORDIC_H: if (cor_done) state_d = ST_SINC_DIV;
      ST_SINC_DIV: begin
        div_start = 1'b1;
        div_n     = 96'(cor_s_abs) << 28;
        div_d     = half_abs;
        state_d   = ST_DIV_SINC;
      end
      ST_DIV_SINC: if (div_done) state_d = ST_SINC_BIG;
      ST_SINC_BIG: state_d = ST_CHORD;
      ST_CHORD: begin
        mul_start = 1'b1;
        mul_a     = 96'(sum_abs);
        mul_b     = sinc_abs[31:0];
        state_d   = ST_MUL_CHORD;
      end
      ST_MUL_CHORD: if (mul_done) state_d = ST_HDW;
      ST_HDW: begin
        div_start = 1'b1;
        div_n     = 96'(hdh_abs);
        div_d     = 64'(ANG_TWO_PI);
        state_d   = ST_DIV_WRAPM;
      end
      ST_DIV_WRAPM: if (div_done) state_d = ST_WRAPM;
      ST_WRAPM: begin
        cor_start = 1'b1;
        cor_ang   = wrap_fix(sgn_q, dr_q);
        state_d   = ST_CORDIC_M;
      end
      ST_CORDIC_M: if (cor_done) state_d = ST_DX;
      ST_DX: begin
        mul_start = 1'b1;
        mul_a     = 96'(chord_abs);
        mul_b     = cor_c_abs;
        state_d   = ST_MUL_DX;
      end
      ST_MUL_DX: if (mul_done) state_d = ST_DY;
      ST_DY: begin
        mul_start = 1'b1;
        mul_a     = 96'(chord_abs);
        mul_b     = sin_abs;
        state_d   = ST_MUL_DY;
      end
      ST_MUL_DY: if (mul_done) state_d = ST_HD;
      ST_HD: begin
        div_start = 1'b1;
        div_n     = 96'(hdt_abs);
        div_d     = 64'(ANG_TWO_PI);
        state_d   = ST_DIV_WRAPT;
      end
      ST_DIV_WRAPT: if (div_done) state_d = ST_LIN;
      ST_LIN: begin
        if (dt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          mul_start = 1'b1;
          mul_a     = 96'(sum_abs);
          mul_b     = LIN_SCALE;
          state_d   = ST_MUL_LIN;
        end
      end
      ST_MUL_LIN: if (mul_done) state_d = ST_LIN_DIV;
      ST_LIN_DIV: begin
        div_start = 1'b1;
        div_n     = mp_q;
        div_d     = 64'(dt_q);
        state_d   = ST_DIV_LIN;
      end
      ST_DIV_LIN: if (div_done) state_d = ST_ANG;
      ST_ANG: begin
        mul_start = 1'b1;
        mul_a     = 96'(turn_abs);
        mul_b     = ANG_SCALE;
        state_d   = ST_MUL_ANG;
      end
      ST_MUL_ANG: if (mul_done) state_d = ST_ANG_DIV;
      ST_ANG_DIV: begin
        div_start = 1'b1;
        div_n     = mp_q;
        div_d     = {20'd0, dt_q, 12'd0};
        state_d   = ST_DIV_ANG;
      end
      ST_DIV_ANG: if (div_done) state_d = ST_DONE;
      ST_DONE: state_d = ST_OUT;
      ST_OUT: if (!m_valid_q || m_axis_tready) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, pose and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= 31'd32768;
      px_q      <= '0;
      py_q      <= '0;
      hd_q      <= '0;
      m_valid_q <= 1'b0;
      dbusy_q   <= 1'b0;
      mbusy_q   <= 1'b0;
      cbusy_q   <= 1'b0;
      dcnt_q    <= '0;
      mcnt_q    <= '0;
      ccnt_q    <= '0;
    end else begin
      if (cfg_valid_i && (cfg_data_i != '0)) w_q <= cfg_data_i;
      // pose commits
      case (state_q)
        ST_DY:   px_q <= sat_pos(px_ext + d_ext);
        ST_HD:   py_q <= sat_pos(py_ext + d_ext);
        ST_LIN:  hd_q <= wrap_fix(sgn_q, dr_q);
        default: ;
      endcase
      // output handshake
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      // unit counters
      if (div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 7'd1;
        if (div_done) dbusy_q <= 1'b0;
      end
      if (mul_start) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + 5'd1;
        if (mul_done) mbusy_q <= 1'b0;
      end
      if (cor_start) begin
        cbusy_q <= 1'b1;
        ccnt_q  <= '0;
      end else if (cbusy_q) begin
        ccnt_q <= ccnt_q + 5'd1;
        if (cor_done) cbusy_q <= 1'b0;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dq_q <= div_n;
      dr_q <= '0;
      dd_q <= div_d;
    end else if (dbusy_q) begin
      dq_q <= {dq_q[DIV_NW-2:0], ~div_s[DIV_DW]};
      dr_q <= div_s[DIV_DW] ? div_t[DIV_DW-1:0] : div_s[DIV_DW-1:0];
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      ma_q <= mul_a;
      mb_q <= mul_b;
      mp_q <= '0;
    end else if (mbusy_q) begin
      if (mb_q[0]) mp_q <= mp_q + ma_q;
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  // rotation-mode cordic, one micro-rotation per cycle
  always_ff @(posedge clk_i) begin
    if (cor_start) begin
      cx_q <= CORDIC_GAIN;
      cy_q <= '0;
      if (cang_e > ANG_HALF_PI) begin
        cz_q   <= 32'(cang_e - ANG_PI);
        cneg_q <= 1'b1;
      end else if (cang_e < -ANG_HALF_PI) begin
        cz_q   <= 32'(cang_e + ANG_PI);
        cneg_q <= 1'b1;
      end else begin
        cz_q   <= 32'(cang_e);
        cneg_q <= 1'b0;
      end
    end else if (cbusy_q) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - (cy_q >>> ccnt_q);
        cy_q <= cy_q + (cx_q >>> ccnt_q);
        cz_q <= cz_q - $signed(atan_unit(ccnt_q));
      end else begin
        cx_q <= cx_q + (cy_q >>> ccnt_q);
        cy_q <= cy_q - (cx_q >>> ccnt_q);
        cz_q <= cz_q + $signed(atan_unit(ccnt_q));
      end
    end
  end

  // per-item datapath captures
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) begin
        sum_q <= in_sum;
        sgn_q <= in_diff[32];
        dt_q  <= s_axis_tdata[95:64];
      end
      ST_SINC_SEL: begin
        turn_q <= turn_v;
        half_q <= half_v;
      end
      ST_H2:         h2_q <= mp_q[59:28];
      ST_H4MUL:      t1_q <= dq_q[31:0];
      ST_SINC_SMALL: sinc_q <= Q28_ONE - $signed({1'b0, t1_q}) + $signed({1'b0, dq_q[31:0]});
      ST_SINC_DIV:   sgn_q <= cor_s[31] ^ half_q[63];
      ST_SINC_BIG:   sinc_q <= sgn_q ? -$signed(dq_q[32:0]) : $signed(dq_q[32:0]);
      ST_CHORD:      sgn_q <= sum_q[32] ^ sinc_q[32];
      ST_HDW: begin
        chord_q <= sp_r29[63:0];
        sgn_q   <= hdh[63];
      end
      ST_DX: begin
        sin_q <= cor_s;
        sgn_q <= chord_q[63] ^ cor_c[31];
      end
      ST_DY: sgn_q <= chord_q[63] ^ sin_q[31];
      ST_HD: sgn_q <= hdt[63];
      ST_LIN: begin
        if (dt_q == '0) begin
          lin_q <= '0;
          ang_q <= '0;
        end
        sgn_q <= sum_q[32];
      end
      ST_ANG: begin
        lin_q <= sat32(sgn_q, dq_q);
        sgn_q <= turn_q[63];
      end
      ST_DONE: ang_q <= sat32(sgn_q, dq_q);
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= {1'b0, ang_q, lin_q, hd_q, sat_out(py_q), sat_out(px_q)};
    end
  end

endmodule

@@ rtl/ddo_checker.sv @@
`include "differential_drive_odometry_unit_macros.svh"

module ddo_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o
);
  import ddo_pkg::*;

  // a stalled result holds
  `DDO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // an accepted request keeps the input closed while it is worked on
  `DDO_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // reported heading stays wrapped
  `DDO_ASSERT_NOW(a_heading_range, m_axis_tvalid, ($signed(m_axis_tdata[126:96]) <= ANG_PI) && ($signed(m_axis_tdata[126:96]) >= -ANG_PI))

  // the configuration port never stalls
  `DDO_ASSERT_NOW(a_cfg_open, cfg_valid_i, cfg_ready_o)

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (.*);
